// ===== rtl/csfw_pkg.sv =====
// ----------------------------------------------------------------------------
// csfw_pkg: shared types and constants of the counting semaphore
// Result codes, fixed field widths and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam int CTR_W = 16;   // semaphore counter and register width
  localparam int CNT_W = 8;    // signal count field
  localparam int REM_W = 7;    // remaining increments, up to 127
  localparam int RC_W  = 5;    // released_count field
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] K_PROCEED  = 3'd0;
  localparam logic [KIND_W-1:0] K_BLOCKED  = 3'd1;
  localparam logic [KIND_W-1:0] K_RELEASED = 3'd2;
  localparam logic [KIND_W-1:0] K_DONE     = 3'd3;
  localparam logic [KIND_W-1:0] K_REFUSED  = 3'd4;

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  typedef struct packed {
    logic in_ready;      // request channel may transfer this cycle
    logic step_release;  // pop the oldest waiter and report it
    logic step_done;     // apply the remaining increments and report done
  } ctrl_cmd_t;

  typedef struct packed {
    logic accept;        // request transfer in this cycle
    logic go_signal;     // offered request is a signal that walks the queue
    logic out_free;      // result register can take a new result
    logic can_release;   // next increment would release a waiter
  } dp_status_t;

endpackage

// ===== rtl/csfw_ifs.sv =====
// ----------------------------------------------------------------------------
// csfw_ifs: request and result channels of the counting semaphore
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface csfw_req_if #(parameter int TID_BITS = 8) ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [TID_BITS-1:0]       thread_id;
  logic signed [7:0]         count;

  modport source (output valid, output op, output thread_id, output count, input ready);
  modport sink (input valid, input op, input thread_id, input count, output ready);
endinterface

interface csfw_rsp_if #(parameter int TID_BITS = 8) ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [TID_BITS-1:0]       thread_id_res;
  logic [4:0]                released_count;
  logic signed [15:0]        value_after;
  logic                      last;

  modport source (output valid, output kind, output thread_id_res, output released_count,
                  output value_after, output last, input ready);
  modport sink (input valid, input kind, input thread_id_res, input released_count,
                input value_after, input last, output ready);
endinterface

// ===== rtl/csfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// csfw_ctrl: sequencer of the counting semaphore
// Takes requests while idle and walks a signal through the wait queue,
// one waiter per fetch and release step.
// ----------------------------------------------------------------------------
module csfw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  csfw_pkg::dp_status_t   status,
  output csfw_pkg::ctrl_cmd_t    cmd
);
  import csfw_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next       = state;
    cmd.in_ready     = 1'b0;
    cmd.step_release = 1'b0;
    cmd.step_done    = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = status.out_free;
        if (status.accept && status.go_signal) begin
          state_next = S_FETCH;
        end
      end
      // The head entry is read into the memory output register here.
      S_FETCH: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        if (status.out_free) begin
          if (status.can_release) begin
            cmd.step_release = 1'b1;
            state_next       = S_FETCH;
          end else begin
            cmd.step_done = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/csfw_datapath.sv =====
// ----------------------------------------------------------------------------
// csfw_datapath: counter, wait queue and result register
// Holds the saturating semaphore counter, the circular queue of waiting
// thread ids in a memory, and the registered result channel.
// ----------------------------------------------------------------------------
module csfw_datapath #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic signed [15:0]            cfg_wdata,
  csfw_req_if.sink                      req,
  csfw_rsp_if.source                    rsp,
  input  csfw_pkg::ctrl_cmd_t           cmd,
  output csfw_pkg::dp_status_t          status
);
  import csfw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);
  localparam logic signed [CTR_W-1:0] CTR_MIN = {1'b1, {(CTR_W-1){1'b0}}};
  localparam logic signed [CTR_W-1:0] CTR_MAX = {1'b0, {(CTR_W-1){1'b1}}};

  logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0] rd_q;

  logic signed [CTR_W-1:0] counter;
  logic [PW-1:0]           head;
  logic [PW-1:0]           tail;
  logic [FW-1:0]           fill;
  logic [REM_W-1:0]        rem;
  logic [RC_W-1:0]         rel_cnt;

  logic                      rsp_valid;
  logic [KIND_W-1:0]         rsp_kind;
  logic [THREAD_ID_BITS-1:0] rsp_tid;
  logic [RC_W-1:0]           rsp_rel;
  logic signed [CTR_W-1:0]   rsp_val;
  logic                      rsp_last;

  logic                      accept;
  logic                      is_wait;
  logic                      push;
  logic                      emit_accept;
  logic [KIND_W-1:0]         acc_kind;
  logic [THREAD_ID_BITS-1:0] acc_tid;
  logic signed [CTR_W-1:0]   acc_val;
  logic signed [CTR_W:0]     bulk_sum;
  logic signed [CTR_W-1:0]   bulk_val;
  logic signed [CTR_W-1:0]   ctr_inc;
  logic [PW-1:0]             head_inc;
  logic [PW-1:0]             tail_inc;

  assign accept  = req.valid && req.ready;
  assign is_wait = (req.op == OP_WAIT);
  assign req.ready = cmd.in_ready;

  assign status.accept      = accept;
  assign status.go_signal   = (req.op == OP_SIGNAL) && !req.count[CNT_W-1];
  assign status.out_free    = !rsp_valid || rsp.ready;
  assign status.can_release = (rem != '0) && counter[CTR_W-1] && (fill != '0);

  assign head_inc = (head == LAST_SLOT) ? '0 : head + PW'(1);
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + PW'(1);

  // Once no waiter can be released, the rest of the increments go in at once.
  assign bulk_sum = {counter[CTR_W-1], counter} + $signed({{(CTR_W+1-REM_W){1'b0}}, rem});
  assign bulk_val = (bulk_sum > $signed({1'b0, CTR_MAX})) ? CTR_MAX : bulk_sum[CTR_W-1:0];
  assign ctr_inc  = counter + CTR_W'(1);

  always_comb begin
    push     = 1'b0;
    acc_kind = K_DONE;
    acc_tid  = '0;
    acc_val  = counter;
    if (is_wait) begin
      if (counter > 0) begin
        acc_kind = K_PROCEED;
        acc_val  = counter - CTR_W'(1);
      end else if (fill == FULL_FILL) begin
        acc_kind = K_REFUSED;
      end else begin
        push     = accept;
        acc_kind = K_BLOCKED;
        acc_tid  = req.thread_id;
        acc_val  = (counter == CTR_MIN) ? counter : counter - CTR_W'(1);
      end
    end
  end

  assign emit_accept = accept && !status.go_signal;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= req.thread_id;
    end
    rd_q <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      rem       <= '0;
      rel_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit_accept || cmd.step_release || cmd.step_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        counter <= cfg_wdata;
        head    <= '0;
        tail    <= '0;
        fill    <= '0;
      end else if (accept) begin
        if (is_wait) begin
          counter <= acc_val;
          if (push) begin
            tail <= tail_inc;
            fill <= fill + FW'(1);
          end
        end else if (status.go_signal) begin
          // A zero count is taken as one increment.
          rem     <= (req.count == '0) ? REM_W'(1) : req.count[REM_W-1:0];
          rel_cnt <= '0;
        end
      end else if (cmd.step_release) begin
        counter <= ctr_inc;
        head    <= head_inc;
        fill    <= fill - FW'(1);
        rem     <= rem - REM_W'(1);
        rel_cnt <= rel_cnt + RC_W'(1);
      end else if (cmd.step_done) begin
        counter <= bulk_val;
        rem     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_accept) begin
      rsp_kind <= acc_kind;
      rsp_tid  <= acc_tid;
      rsp_rel  <= '0;
      rsp_val  <= acc_val;
      rsp_last <= 1'b1;
    end else if (cmd.step_release) begin
      rsp_kind <= K_RELEASED;
      rsp_tid  <= rd_q;
      rsp_rel  <= '0;
      rsp_val  <= ctr_inc;
      rsp_last <= 1'b0;
    end else if (cmd.step_done) begin
      rsp_kind <= K_DONE;
      rsp_tid  <= '0;
      rsp_rel  <= rel_cnt;
      rsp_val  <= bulk_val;
      rsp_last <= 1'b1;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.kind           = rsp_kind;
  assign rsp.thread_id_res  = rsp_tid;
  assign rsp.released_count = rsp_rel;
  assign rsp.value_after    = rsp_val;
  assign rsp.last           = rsp_last;

endmodule

// ===== rtl/counting_semaphore_fifo_waiters_top.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_top: counting semaphore with a wait queue
// A wait request decrements the counter and proceeds or blocks and queues
// its thread id, or is refused, counter kept, when the queue is full. A signal
// request adds a non-negative count, releasing the oldest waiters in order;
// each released thread is one result; a final done result gives the total.
// The request channel transfers only while the block is idle and its result
// register is free. A wait or a negative-count signal gives its single
// result in the cycle after the transfer. Per released thread, a signal runs
// a fetch state (read the queue head from the memory read port) and a step
// state (pop it), a last pair gives the done result, then a request may follow.
// All results sit in an output register; while the receiver stalls it holds
// its result and the sequencer waits before producing the next one.
// Reset clears the counter to zero and empties the queue; no clearing pass
// runs. A write on cfg_we reloads the counter and empties the queue; the user
// must issue it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_top #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata,
  csfw_req_if.sink           req,
  csfw_rsp_if.source         rsp
);
  import csfw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  csfw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  csfw_datapath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== dv/counting_semaphore_fifo_waiters_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_top_test: self-checking bench of the semaphore
// A directed table covers the extremes and special cases. Phases of random
// waits and signals follow, each after a reload of the initial value. Every
// result is compared with its table row or a cycle-free counter and queue model.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_top_test;
  import csfw_pkg::*;

  localparam int WAIT_SLOTS   = 16;
  localparam int PHASE_ITEMS  = 40;
  localparam int PHASES       = 6;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         tid;
    logic [4:0]         rel;
    logic signed [15:0] val;
    logic               last;
  } sem_result_t;

  // For rows with is_cfg set, val holds the initial value to load.
  typedef struct packed {
    logic               is_cfg;
    logic               op;
    logic [7:0]         tid;
    logic signed [7:0]  cnt;
    logic [4:0]         reps;
    logic               typed;
    logic [2:0]         kind;
    logic signed [15:0] val;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{1'b0, OP_SIGNAL, 8'h00, -8'sd1,   5'd1,  1'b1, K_DONE,     16'sd0},
    '{1'b0, OP_WAIT,   8'h00, 8'sd0,    5'd1,  1'b1, K_BLOCKED,  -16'sd1},
    '{1'b0, OP_WAIT,   8'hFF, 8'sd0,    5'd1,  1'b1, K_BLOCKED,  -16'sd2},
    '{1'b0, OP_SIGNAL, 8'h00, 8'sd0,    5'd1,  1'b0, K_DONE,     16'sd0},
    '{1'b0, OP_SIGNAL, 8'hFF, 8'sd127,  5'd1,  1'b0, K_DONE,     16'sd0},
    '{1'b0, OP_WAIT,   8'hA5, 8'sd0,    5'd1,  1'b1, K_PROCEED,  16'sd125},
    '{1'b0, OP_SIGNAL, 8'h00, 8'sh80,   5'd1,  1'b1, K_DONE,     16'sd125},
    '{1'b1, OP_WAIT,   8'h00, 8'sd0,    5'd0,  1'b0, K_DONE,     16'sh7FFF},
    '{1'b0, OP_SIGNAL, 8'h00, 8'sd127,  5'd1,  1'b1, K_DONE,     16'sh7FFF},
    '{1'b0, OP_WAIT,   8'h5A, 8'sd0,    5'd1,  1'b1, K_PROCEED,  16'sh7FFE},
    '{1'b1, OP_WAIT,   8'h00, 8'sd0,    5'd0,  1'b0, K_DONE,     16'sh8000},
    '{1'b0, OP_WAIT,   8'h01, 8'sd0,    5'd16, 1'b1, K_BLOCKED,  16'sh8000},
    '{1'b0, OP_WAIT,   8'h77, 8'sd0,    5'd1,  1'b1, K_REFUSED,  16'sh8000},
    '{1'b0, OP_SIGNAL, 8'h00, 8'sd127,  5'd1,  1'b0, K_DONE,     16'sd0},
    '{1'b1, OP_WAIT,   8'h00, 8'sd0,    5'd0,  1'b0, K_DONE,     -16'sd1},
    '{1'b0, OP_WAIT,   8'h33, 8'sd0,    5'd1,  1'b1, K_BLOCKED,  -16'sd2},
    '{1'b0, OP_WAIT,   8'hC3, 8'sd0,    5'd1,  1'b1, K_BLOCKED,  -16'sd3},
    '{1'b1, OP_WAIT,   8'h00, 8'sd0,    5'd0,  1'b0, K_DONE,     16'sd2},
    '{1'b0, OP_SIGNAL, 8'h00, 8'sd5,    5'd1,  1'b1, K_DONE,     16'sd7},
    '{1'b0, OP_WAIT,   8'h44, 8'sd0,    5'd1,  1'b1, K_PROCEED,  16'sd6},
    '{1'b1, OP_WAIT,   8'h00, 8'sd0,    5'd0,  1'b0, K_DONE,     -16'sd2},
    '{1'b0, OP_SIGNAL, 8'h00, 8'sd3,    5'd1,  1'b1, K_DONE,     16'sd1}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic signed [15:0] cfg_wdata;

  csfw_req_if #(.TID_BITS(8)) req_ch ();
  csfw_rsp_if #(.TID_BITS(8)) rsp_ch ();

  counting_semaphore_fifo_waiters_top #(
    .QUEUE_DEPTH   (WAIT_SLOTS),
    .THREAD_ID_BITS(8)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: the counter kept wide so saturation is explicit.
  int          sem_count;
  logic [7:0]  waiter_ids [$];
  sem_result_t due_results [$];
  sem_result_t op_results [$];

  int bad_results;
  int burst_left;
  int n_waits, n_signals, n_reloads;
  int n_proceed, n_blocked, n_released, n_done, n_refused;

  function automatic void note_result(logic [2:0] kind, logic [7:0] tid, logic [4:0] rel,
                                      logic last);
    sem_result_t r;
    r.kind = kind;
    r.tid  = tid;
    r.rel  = rel;
    r.val  = 16'(sem_count);
    r.last = last;
    op_results.push_back(r);
  endfunction

  function automatic void predict_semaphore_op(logic op, logic [7:0] tid,
                                               logic signed [7:0] cnt);
    int   steps;
    int   freed;
    logic was_neg;
    op_results.delete();
    if (op == OP_WAIT) begin
      if (sem_count > 0) begin
        sem_count--;
        note_result(K_PROCEED, 8'd0, 5'd0, 1'b1);
      end else if (waiter_ids.size() >= WAIT_SLOTS) begin
        note_result(K_REFUSED, 8'd0, 5'd0, 1'b1);
      end else begin
        if (sem_count > -32768) sem_count--;
        waiter_ids.push_back(tid);
        note_result(K_BLOCKED, tid, 5'd0, 1'b1);
      end
    end else if (cnt < 0) begin
      note_result(K_DONE, 8'd0, 5'd0, 1'b1);
    end else begin
      steps = (cnt == 0) ? 1 : int'(cnt);
      freed = 0;
      for (int i = 0; i < steps; i++) begin
        was_neg = sem_count < 0;
        if (sem_count < 32767) sem_count++;
        // A negative counter with nobody queued just counts up silently.
        if (was_neg && waiter_ids.size() > 0) begin
          freed++;
          note_result(K_RELEASED, waiter_ids.pop_front(), 5'd0, 1'b0);
        end
      end
      note_result(K_DONE, 8'd0, 5'(freed), 1'b1);
    end
  endfunction

  task automatic send_req(input logic op, input logic [7:0] tid, input logic signed [7:0] cnt,
                          input logic typed, input sem_result_t typed_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 14);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.thread_id <= tid;
    req_ch.count     <= cnt;
    do @(posedge clk); while (!req_ch.ready);
    predict_semaphore_op(op, tid, cnt);
    if (typed) begin
      due_results.push_back(typed_res);
    end else begin
      foreach (op_results[i]) due_results.push_back(op_results[i]);
    end
    if (op == OP_WAIT) n_waits++;
    else n_signals++;
  endtask

  // Hold off requests until every outstanding result has been taken.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic load_initial(input logic signed [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sem_count = int'(value);
    waiter_ids.delete();
    n_reloads++;
  endtask

  // Receiver back-pressure: always ready, random, or a fixed pattern, picked at random.
  int stall_cycle;
  int stall_mode;
  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 48 == 0) stall_mode = $urandom_range(0, 2);
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        default: rsp_ch.ready <= ((stall_cycle % 7) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    sem_result_t want;
    sem_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.kind, rsp_ch.thread_id_res, rsp_ch.released_count,
              rsp_ch.value_after, rsp_ch.last};
      case (got.kind)
        K_PROCEED:  n_proceed++;
        K_BLOCKED:  n_blocked++;
        K_RELEASED: n_released++;
        K_DONE:     n_done++;
        default:    n_refused++;
      endcase
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: kind %0d tid %0d rel %0d val %0d last %0d",
                   got.kind, got.tid, got.rel, got.val, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch at %0t: expected kind %0d tid %0d rel %0d val %0d last %0d",
                     $realtime, want.kind, want.tid, want.rel, want.val, want.last);
            $display("               got kind %0d tid %0d rel %0d val %0d last %0d",
                     got.kind, got.tid, got.rel, got.val, got.last);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    plan_row_t         row;
    sem_result_t       typed_res;
    logic              op;
    logic signed [7:0] cnt;
    logic signed [15:0] start_val;
    int                wait_pct;
    int                pick;
    int                spins;

    rst              = 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.op        <= OP_WAIT;
    req_ch.thread_id <= '0;
    req_ch.count     <= '0;
    sem_count        = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = DIRECTED_PLAN[r];
      if (row.is_cfg) begin
        load_initial(row.val);
      end else begin
        for (int i = 0; i < int'(row.reps); i++) begin
          typed_res.kind = row.kind;
          typed_res.tid  = (row.kind == K_BLOCKED) ? row.tid + 8'(i) : 8'd0;
          typed_res.rel  = 5'd0;
          typed_res.val  = row.val;
          typed_res.last = 1'b1;
          send_req(row.op, row.tid + 8'(i), row.cnt, row.typed, typed_res);
        end
      end
    end

    typed_res = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3)      start_val = 16'sh8000;
      else if (ph == 4) start_val = 16'sh7FF0;
      else              start_val = 16'($urandom_range(0, 12)) - 16'd6;
      load_initial(start_val);
      wait_pct = (ph % 3 == 0) ? 50 : (ph % 3 == 1) ? 65 : 35;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op   = ($urandom_range(0, 99) < wait_pct) ? OP_WAIT : OP_SIGNAL;
        pick = $urandom_range(0, 99);
        if (pick < 60)      cnt = 8'($urandom_range(0, 3));
        else if (pick < 75) cnt = 8'($urandom_range(4, 20));
        else if (pick < 88) cnt = 8'($urandom_range(128, 255));
        else                cnt = 8'($urandom_range(21, 127));
        send_req(op, 8'($urandom_range(0, 255)), cnt, 1'b0, typed_res);
      end
    end

    req_ch.valid <= 1'b0;
    spins = 0;
    while (due_results.size() != 0 && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d waits and %0d signals over %0d counter reloads.",
             n_waits, n_signals, n_reloads);
    $display("Saw %0d proceed, %0d blocked, %0d released, %0d done, %0d refused; %0d bad.",
             n_proceed, n_blocked, n_released, n_done, n_refused, bad_results);
    if (due_results.size() != 0)
      $display("%0d expected results never arrived", due_results.size());
    if (bad_results == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/csfw_pkg.sv
rtl/csfw_ifs.sv
rtl/csfw_ctrl.sv
rtl/csfw_datapath.sv
rtl/counting_semaphore_fifo_waiters_top.sv
dv/counting_semaphore_fifo_waiters_top_test.sv
